// ===== sv/pattern_avoiding_matrix_counter_assert.svh =====
// ----------------------------------------------------------------------------
// pattern_avoiding_matrix_counter_assert
// Assertion macros used by the checker of the pattern avoiding counter
// ----------------------------------------------------------------------------
`ifndef PATTERN_AVOIDING_MATRIX_COUNTER_ASSERT_SVH
`define PATTERN_AVOIDING_MATRIX_COUNTER_ASSERT_SVH

// property checked outside reset
`define PAMC_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("pamc assertion failed");

// property checked at every edge, reset included
`define PAMC_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("pamc assertion failed");

`endif

// ===== sv/pamc_pkg.sv =====
// ----------------------------------------------------------------------------
// pamc_pkg
// Types, widths and the row compatibility test of the pattern avoiding counter
// ----------------------------------------------------------------------------
package pamc_pkg;

  // largest dimension any build supports
  localparam int DIM_LIMIT   = 7;
  localparam int DIM_W       = 3;
  localparam int MASK_W      = 16;
  localparam int COUNT_W     = 37;

  typedef logic [DIM_W-1:0]     dim_t;
  typedef logic [MASK_W-1:0]    mask_t;
  typedef logic [COUNT_W-1:0]   count_t;
  typedef logic [DIM_LIMIT-1:0] row_t;

  // per-cell control from the sequencer
  typedef struct packed {
    logic active;  // cell holds a row above the one being tried
    logic load;    // capture the candidate row
  } cell_ctrl_t;

  // true when no column pair of upper row up and lower row lo is forbidden
  function automatic logic rows_ok(row_t up, row_t lo, dim_t ncols, mask_t mask);
    logic       ok;
    logic [3:0] p;
    ok = 1'b1;
    for (int a = 0; a < DIM_LIMIT; a++) begin
      for (int b = a + 1; b < DIM_LIMIT; b++) begin
        p = {up[a], up[b], lo[a], lo[b]};
        if ((b < int'(ncols)) && mask[p]) begin
          ok = 1'b0;
        end
      end
    end
    return ok;
  endfunction

endpackage

// ===== sv/pamc_if.sv =====
// ----------------------------------------------------------------------------
// pamc_in_if / pamc_out_if
// Valid/ready channels for requests and counts
// ----------------------------------------------------------------------------
interface pamc_in_if;
  logic                 valid;
  logic                 ready;
  pamc_pkg::dim_t       rows;
  pamc_pkg::dim_t       cols;
  pamc_pkg::mask_t      forbidden_mask;
  modport source (output valid, rows, cols, forbidden_mask, input ready);
  modport sink   (input valid, rows, cols, forbidden_mask, output ready);
endinterface

interface pamc_out_if;
  logic                 valid;
  logic                 ready;
  pamc_pkg::count_t     matrix_count;
  modport source (output valid, matrix_count, input ready);
  modport sink   (input valid, matrix_count, output ready);
endinterface

// ===== sv/pattern_avoiding_matrix_counter.sv =====
// ----------------------------------------------------------------------------
// pattern_avoiding_matrix_counter
// Counts binary matrices avoiding a set of forbidden 2x2 patterns
// ----------------------------------------------------------------------------
//  channel  direction  payload
//  in_ch    sink       rows, cols, forbidden_mask
//  out_ch   source     matrix_count
//
//  Row-wise depth first search: one candidate row is tried per cycle against
//  a chain of MAX_DIM cells holding the rows already placed; zero dimensions
//  skip the search and give a count of one.
//  One request at a time; the next is taken while a count waits on out_ch.
//  Reset is synchronous and clears the sequencer and the output valid flag.
// ----------------------------------------------------------------------------
module pattern_avoiding_matrix_counter #(
  parameter int MAX_DIM = 6
) (
  input  logic clk,
  input  logic rst_n,
  pamc_in_if.sink    in_ch,
  pamc_out_if.source out_ch
);
  import pamc_pkg::*;

  localparam int VW = MAX_DIM + 1;
  localparam int DW = $clog2(MAX_DIM);

  typedef enum logic [1:0] {S_IDLE, S_RUN, S_DONE} state_t;

  state_t          state_r;
  dim_t            nrows_r, ncols_r;
  mask_t           mask_r;
  logic [DW-1:0]   depth_r;
  logic [VW-1:0]   cand_r;
  count_t          count_r;
  logic            out_valid_r;
  count_t          out_count_r;

  logic                ok_chain [MAX_DIM+1];
  logic [MAX_DIM-1:0]  row_q [MAX_DIM];
  cell_ctrl_t          ctrl [MAX_DIM];
  logic                exhausted, last_row, descend;
  logic                out_load;
  dim_t                rows_sat, cols_sat;

  // saturate requested dimensions
  assign rows_sat = (int'(in_ch.rows) > MAX_DIM) ? dim_t'(MAX_DIM) : in_ch.rows;
  assign cols_sat = (int'(in_ch.cols) > MAX_DIM) ? dim_t'(MAX_DIM) : in_ch.cols;

  assign exhausted = (cand_r == (VW'(1) << ncols_r));
  assign last_row  = (depth_r == DW'(nrows_r - dim_t'(1)));
  assign descend   = (state_r == S_RUN) && !exhausted && ok_chain[MAX_DIM] && !last_row;

  // finished count moves into the output register
  assign out_load  = (state_r == S_DONE) && (!out_valid_r || out_ch.ready);

  // chain of row cells
  assign ok_chain[0] = 1'b1;
  for (genvar k = 0; k < MAX_DIM; k++) begin : g_cell
    assign ctrl[k].active = (DW'(k) < depth_r);
    assign ctrl[k].load   = descend && (depth_r == DW'(k));
    pamc_cell #(.RW(MAX_DIM)) u_cell (
      .clk    (clk),
      .ctrl   (ctrl[k]),
      .cand   (cand_r[MAX_DIM-1:0]),
      .ncols  (ncols_r),
      .mask   (mask_r),
      .ok_in  (ok_chain[k]),
      .ok_out (ok_chain[k+1]),
      .row_q  (row_q[k])
    );
  end

  // search sequencer and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_r <= 1'b1;
        out_count_r <= count_r;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_ch.valid) begin
            nrows_r <= rows_sat;
            ncols_r <= cols_sat;
            mask_r  <= in_ch.forbidden_mask;
            depth_r <= '0;
            cand_r  <= '0;
            if (rows_sat == '0 || cols_sat == '0) begin
              count_r <= count_t'(1);
              state_r <= S_DONE;
            end else begin
              count_r <= '0;
              state_r <= S_RUN;
            end
          end
        end
        S_RUN: begin
          if (exhausted) begin
            if (depth_r == '0) begin
              state_r <= S_DONE;
            end else begin
              depth_r <= depth_r - DW'(1);
              cand_r  <= VW'(row_q[depth_r - DW'(1)]) + VW'(1);
            end
          end else if (ok_chain[MAX_DIM] && last_row) begin
            count_r <= count_r + count_t'(1);
            cand_r  <= cand_r + VW'(1);
          end else if (ok_chain[MAX_DIM]) begin
            depth_r <= depth_r + DW'(1);
            cand_r  <= '0;
          end else begin
            cand_r  <= cand_r + VW'(1);
          end
        end
        S_DONE: begin
          if (out_load) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_ch.ready         = (state_r == S_IDLE);
  assign out_ch.valid        = out_valid_r;
  assign out_ch.matrix_count = out_count_r;

endmodule

// ===== sv/pamc_cell.sv =====
// ----------------------------------------------------------------------------
// pamc_cell
// One row slot of the search: holds a placed row and tests the candidate
// ----------------------------------------------------------------------------
module pamc_cell #(
  parameter int RW = 6
) (
  input  logic                 clk,
  input  pamc_pkg::cell_ctrl_t ctrl,
  input  logic [RW-1:0]        cand,
  input  pamc_pkg::dim_t       ncols,
  input  pamc_pkg::mask_t      mask,
  input  logic                 ok_in,
  output logic                 ok_out,
  output logic [RW-1:0]        row_q
);
  import pamc_pkg::*;

  logic [RW-1:0] row_r;

  // capture the row placed at this depth
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      row_r <= cand;
    end
  end

  // pass the compatibility verdict down the chain
  assign ok_out = ok_in & (~ctrl.active |
                  rows_ok(row_t'(row_r), row_t'(cand), ncols, mask));
  assign row_q  = row_r;

endmodule

// ===== sv/pamc_checker.sv =====
// ----------------------------------------------------------------------------
// pamc_checker
// Port-level checks of the pattern avoiding counter, bound to the top level
// ----------------------------------------------------------------------------
`include "pattern_avoiding_matrix_counter_assert.svh"

module pamc_checker (
  input logic             clk,
  input logic             rst_n,
  input logic             in_valid,
  input logic             in_ready,
  input logic             out_valid,
  input logic             out_ready,
  input pamc_pkg::count_t out_count
);
  import pamc_pkg::*;

  // a stalled count holds
  `PAMC_ASSERT(a_out_hold, clk, rst_n, (out_valid && !out_ready) |=> (out_valid && $stable(out_count)))
  // the block is busy right after taking a transaction
  `PAMC_ASSERT(a_busy, clk, rst_n, (in_valid && in_ready) |=> !in_ready)
  // reset empties the output
  `PAMC_ASSERT_ALWAYS(a_reset, clk, !rst_n |=> !out_valid)

endmodule

bind pattern_avoiding_matrix_counter pamc_checker u_pamc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_count (out_ch.matrix_count)
);
